/* hw/rtl/hji_pkg.sv */
// Shared types, sizes and command codes of the hash-join intersect engine.
// No dependencies; imported by the engine and its port checker.
package hji_pkg;

    localparam int KEY_BYTES  = 8;
    localparam int HASH_BITS  = 16;
    localparam int POOL_DEPTH = 1024;

    localparam int KEY_W   = 64;
    localparam int HASH_G  = HASH_BITS / 8;          // byte lanes in the hash
    localparam int BUCKETS = 1 << HASH_BITS;
    localparam int IDX_W   = $clog2(POOL_DEPTH);     // node index
    localparam int PTR_W   = $clog2(POOL_DEPTH + 1); // node index or null

    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_DEPTH);
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_PROBE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic ST_MATCH = 1'b0;
    localparam logic ST_DROP  = 1'b1;

    typedef logic [PTR_W-1:0]     t_ptr;
    typedef logic [HASH_BITS-1:0] t_hash;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key_value;
    } t_item;

    typedef struct packed {
        logic             status;
        logic [KEY_W-1:0] matched_key;
    } t_result;

endpackage

/* hw/rtl/hash_join_intersect.sv */
// Hash-join intersect engine: bucket heads, node pool and the chain walker.
// Depends on hji_pkg.
//
// Usage:
//   Command channel: a word on i_item is taken at a clock edge with start high
//   and busy low. command selects insert (push key onto its bucket chain),
//   probe (walk the chain, echo the key on the first equal node and unlink it)
//   or clear (empty the table). Code three is ignored.
//   Result channel: o_strobe is high for exactly one cycle with o_result; the
//   receiver cannot stall it. A probe hit gives status ST_MATCH and the key; an
//   insert into a full pool gives status ST_DROP and a zero key. A successful
//   insert and a probe miss give no word.
// Sequencing:
//   Clear and code three leave busy low.
//   Insert: hash, head read, node read, write-back; no node read on an empty bucket or full pool.
//   Probe: hash and head read, then the chain walk; the walk reads one
//   node per cycle through the single node-memory read port and the shared
//   key comparator. The result strobe follows in the cycle after the last compare.
// Reset:
//   Synchronous, active low. No clearing pass: the head memory is left as it
//   is, and a head is trusted only when it points below the fill count and the
//   node it names carries the same bucket hash. Clear just zeroes the count.
module hash_join_intersect (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  hji_pkg::t_item  i_item,
    output logic            o_strobe,
    output hji_pkg::t_result o_result
);
    import hji_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HASH = 2'd1;
    localparam logic [1:0] S_HEAD = 2'd2;
    localparam logic [1:0] S_NODE = 2'd3;

    // byte-lane weighted sum, modulo 2^HASH_BITS
    function automatic t_hash f_hash(input logic [KEY_W-1:0] k);
        t_hash sum;
        sum = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            sum = sum + (HASH_BITS'(k[8*i +: 8]) << (8 * (HASH_G - 1 - (i % HASH_G))));
        end
        return sum;
    endfunction

    // bytes agree up to and including the first zero byte
    function automatic logic f_keys_equal(input logic [KEY_W-1:0] a,
                                          input logic [KEY_W-1:0] b);
        logic eq;
        logic stop;
        eq   = 1'b1;
        stop = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (!stop) begin
                if (a[8*i +: 8] != b[8*i +: 8]) begin
                    eq   = 1'b0;
                    stop = 1'b1;
                end else if (a[8*i +: 8] == 8'd0) begin
                    stop = 1'b1;
                end
            end
        end
        return eq;
    endfunction

    // control state
    logic [1:0]       r_state, n_state;
    logic [PTR_W-1:0] r_used, n_used;
    logic             r_strobe, n_strobe;

    // item context
    logic [1:0]       r_cmd;
    logic [KEY_W-1:0] r_key;
    t_hash            r_hash;
    t_ptr             r_cur, n_cur;
    t_ptr             r_prev, n_prev;
    t_result          r_result, n_result;

    // memories and their registered read data
    t_ptr             r_head_mem [BUCKETS];
    t_ptr             r_head_rd;
    logic [KEY_W-1:0] r_nkey_mem [POOL_DEPTH];
    t_ptr             r_nnext_mem [POOL_DEPTH];
    t_hash            r_nhash_mem [POOL_DEPTH];
    logic [KEY_W-1:0] r_nkey_rd;
    t_ptr             r_nnext_rd;
    t_hash            r_nhash_rd;

    // memory controls
    logic             w_head_we;
    t_ptr             w_head_wdata;
    logic             w_ins_we;
    logic             w_next_we;
    logic [IDX_W-1:0] w_next_waddr;
    t_ptr             w_next_wdata;
    logic             w_node_re;
    logic [IDX_W-1:0] w_node_raddr;
    logic             w_accept;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_strobe     = 1'b0;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_result     = r_result;
        w_head_we    = 1'b0;
        w_head_wdata = NIL;
        w_ins_we     = 1'b0;
        w_next_we    = 1'b0;
        w_next_waddr = r_used[IDX_W-1:0];
        w_next_wdata = NIL;
        w_node_re    = 1'b0;
        w_node_raddr = r_head_rd[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_item.command)
                        CMD_INSERT: n_state = S_HASH;
                        CMD_PROBE:  n_state = S_HASH;
                        CMD_CLEAR:  n_used  = '0;
                        default:    ;
                    endcase
                end
            end
            S_HASH: begin
                // head read issued this cycle
                n_state = S_HEAD;
                n_prev  = NIL;
            end
            S_HEAD: begin
                if (r_cmd == CMD_INSERT && r_used == NIL) begin
                    n_result.status      = ST_DROP;
                    n_result.matched_key = '0;
                    n_strobe             = 1'b1;
                    n_state              = S_IDLE;
                end else if (r_head_rd < r_used) begin
                    w_node_re    = 1'b1;
                    w_node_raddr = r_head_rd[IDX_W-1:0];
                    n_cur        = r_head_rd;
                    n_state      = S_NODE;
                end else if (r_cmd == CMD_INSERT) begin
                    // stale or empty head: new node ends the chain
                    w_ins_we     = 1'b1;
                    w_next_we    = 1'b1;
                    w_next_wdata = NIL;
                    w_head_we    = 1'b1;
                    w_head_wdata = r_used;
                    n_used       = r_used + PTR_W'(1);
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_NODE: begin
                if (r_cmd == CMD_INSERT) begin
                    w_ins_we     = 1'b1;
                    w_next_we    = 1'b1;
                    if (r_nhash_rd == r_hash) begin
                        w_next_wdata = r_cur;
                    end else begin
                        w_next_wdata = NIL;
                    end
                    w_head_we    = 1'b1;
                    w_head_wdata = r_used;
                    n_used       = r_used + PTR_W'(1);
                    n_state      = S_IDLE;
                end else if (r_nhash_rd != r_hash) begin
                    // head left over from before a clear
                    n_state = S_IDLE;
                end else if (f_keys_equal(r_key, r_nkey_rd)) begin
                    if (r_prev == NIL) begin
                        w_head_we    = 1'b1;
                        w_head_wdata = r_nnext_rd;
                    end else begin
                        w_next_we    = 1'b1;
                        w_next_waddr = r_prev[IDX_W-1:0];
                        w_next_wdata = r_nnext_rd;
                    end
                    n_result.status      = ST_MATCH;
                    n_result.matched_key = r_key;
                    n_strobe             = 1'b1;
                    n_state              = S_IDLE;
                end else if (r_nnext_rd < r_used) begin
                    w_node_re    = 1'b1;
                    w_node_raddr = r_nnext_rd[IDX_W-1:0];
                    n_prev       = r_cur;
                    n_cur        = r_nnext_rd;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_item.command;
            r_key  <= i_item.key_value & KEY_MASK;
            r_hash <= f_hash(i_item.key_value & KEY_MASK);
        end
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_result <= n_result;
    end

    // bucket head memory
    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            r_head_mem[r_hash] <= w_head_wdata;
        end
        r_head_rd <= r_head_mem[r_hash];
    end

    // node pool
    always_ff @(posedge i_clk) begin
        if (w_ins_we) begin
            r_nkey_mem[r_used[IDX_W-1:0]]  <= r_key;
            r_nhash_mem[r_used[IDX_W-1:0]] <= r_hash;
        end
        if (w_next_we) begin
            r_nnext_mem[w_next_waddr] <= w_next_wdata;
        end
        if (w_node_re) begin
            r_nkey_rd  <= r_nkey_mem[w_node_raddr];
            r_nnext_rd <= r_nnext_mem[w_node_raddr];
            r_nhash_rd <= r_nhash_mem[w_node_raddr];
        end
    end

endmodule

/* hw/rtl/hji_checker.sv */
// Port-level checker for the hash-join intersect engine, bound to its top.
// Depends on hji_pkg.
module hji_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input hji_pkg::t_item   i_item,
    input logic             o_strobe,
    input hji_pkg::t_result o_result
);
    import hji_pkg::*;

    // table walks hold the command port off in the next cycle
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.command == CMD_INSERT || i_item.command == CMD_PROBE))
        |=> busy)
        else $error("insert/probe did not raise busy");

    // clear and unused codes finish in the cycle they are taken
    a_clear_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !(i_item.command == CMD_INSERT || i_item.command == CMD_PROBE))
        |=> !busy)
        else $error("clear left the engine busy");

    // a result closes a walk
    a_strobe_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (!busy && $past(busy)))
        else $error("result word outside a walk");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_DROP) |-> (o_result.matched_key == '0))
        else $error("dropped insert carries a key");

endmodule

bind hash_join_intersect hji_checker u_hji_checker (.*);

/* bench/tb_hash_join_intersect.sv */
`timescale 1ns / 1ps
// Self-checking bench for hash_join_intersect: directed rows, then random build/probe traffic.
// Depends on hji_pkg and the hash_join_intersect RTL only.
module tb_hash_join_intersect;
    import hji_pkg::*;

    // Code three has no name in the package; the engine ignores it.
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0] KEY_SEQ  = 64'h0807_0605_0403_0201;
    // Three keys in one bucket: even bytes permuted among themselves.
    localparam logic [KEY_W-1:0] KEY_A    = 64'h8877_6655_4433_2211;
    localparam logic [KEY_W-1:0] KEY_B    = 64'h8877_6655_4411_2233;
    localparam logic [KEY_W-1:0] KEY_C    = 64'h8877_6611_4433_2255;
    // Equal up to the terminator, tails differ but hash alike.
    localparam logic [KEY_W-1:0] KEY_T1   = 64'h0000_0002_0001_0041;
    localparam logic [KEY_W-1:0] KEY_T2   = 64'h0000_0001_0002_0041;
    localparam logic [KEY_W-1:0] KEY_D    = 64'h0123_4567_89AB_CDEF;

    localparam t_result NO_WORD = '0;
    localparam int RANDOM_ITEMS = 400;
    localparam int TAIL_CYCLES  = POOL_DEPTH + 16;  // longest chain walk plus margin

    typedef struct {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        bit               pinned;  // expectation typed into the row
        bit               hit;     // pinned row yields a word
        t_result          word;
    } t_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_item    i_item = '0;
    logic     o_strobe;
    t_result  o_result;

    // Expectation of the word in flight, handed to the checker with the item.
    bit       pin_on = 1'b0;
    bit       pin_hit = 1'b0;
    t_result  pin_word = '0;

    // Shadow of the engine's table.
    int               bucket_top [BUCKETS];
    logic [KEY_W-1:0] node_key_sh [POOL_DEPTH];
    int               node_link [POOL_DEPTH];
    int               pool_fill;

    t_result          owed_results[$];
    logic [KEY_W-1:0] base_keys[$];
    int               fail_count = 0;
    int               burst_left = 0;

    hash_join_intersect dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Byte i lands at lane (i mod g); lane 0 is the most significant byte.
    function automatic t_hash bucket_of(logic [KEY_W-1:0] k);
        logic [63:0] acc;
        int          g;
        acc = '0;
        g = (HASH_G == 0) ? 1 : HASH_G;
        for (int i = 0; i < KEY_BYTES; i++)
            acc += 64'(k[8*i +: 8]) << (8 * (g - 1 - (i % g)));
        return acc[HASH_BITS-1:0];
    endfunction

    // C-string style compare: stop after the first zero byte.
    function automatic bit same_key(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (a[8*i +: 8] != b[8*i +: 8])
                return 1'b0;
            if (a[8*i +: 8] == 8'h00)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic empty_table();
        foreach (bucket_top[i])
            bucket_top[i] = POOL_DEPTH;
        pool_fill = 0;
    endtask

    // Applies one command to the shadow table; found=1 when a word is due.
    task automatic join_step(input t_item it, output bit found, output t_result word);
        logic [KEY_W-1:0] key;
        t_hash            h;
        int               cur;
        int               prev;
        int               steps;
        key   = it.key_value & KEY_MASK;
        found = 1'b0;
        word  = NO_WORD;
        h     = bucket_of(key);
        case (it.command)
            CMD_INSERT: begin
                if (pool_fill >= POOL_DEPTH) begin
                    found = 1'b1;
                    word.status = ST_DROP;
                end else begin
                    node_key_sh[pool_fill] = key;
                    node_link[pool_fill]   = bucket_top[h];
                    bucket_top[h]          = pool_fill;
                    pool_fill++;
                end
            end
            CMD_PROBE: begin
                prev  = POOL_DEPTH;
                cur   = bucket_top[h];
                steps = 0;
                while (!found && cur < POOL_DEPTH && steps < POOL_DEPTH) begin
                    if (same_key(key, node_key_sh[cur])) begin
                        // unlink, head included
                        if (prev == POOL_DEPTH)
                            bucket_top[h] = node_link[cur];
                        else
                            node_link[prev] = node_link[cur];
                        found = 1'b1;
                        word.status      = ST_MATCH;
                        word.matched_key = key;
                    end else begin
                        prev = cur;
                        cur  = node_link[cur];
                        steps++;
                    end
                end
            end
            CMD_CLEAR: empty_table();
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Checker: result words first, then the item taken at this edge
    // ---------------------------------------------------------------

    function automatic void flag_error(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: mismatch: %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        bit      fresh;
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                got = o_result;
                if (owed_results.size() == 0) begin
                    flag_error($sformatf("word with nothing owed: status %0d key %h",
                                         got.status, got.matched_key));
                end else begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status)
                        flag_error($sformatf("status exp %0d got %0d", want.status,
                                             got.status));
                    if (got.matched_key !== want.matched_key)
                        flag_error($sformatf("matched_key exp %h got %h",
                                             want.matched_key, got.matched_key));
                end
            end
            if (start && !busy) begin
                join_step(i_item, fresh, want);
                if (pin_on) begin
                    if (pin_hit)
                        owed_results.push_back(pin_word);
                end else if (fresh) begin
                    owed_results.push_back(want);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------

    // Bursts of back-to-back words with random gaps; some long gap-free runs.
    task automatic send_word(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                             input bit pinned = 1'b0, input bit hit = 1'b0,
                             input t_result word = '0);
        t_item w;
        int    gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(30, 60);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(0, 7);
            end
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        w.command   = cmd;
        w.key_value = key;
        start    <= 1'b1;
        i_item   <= w;
        pin_on   <= pinned;
        pin_hit  <= hit;
        pin_word <= word;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Hold off until every owed word is out and the engine is idle.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (owed_results.size() != 0 || busy !== 1'b0);
    endtask

    // ---------------------------------------------------------------
    // Key generation
    // ---------------------------------------------------------------

    function automatic logic [KEY_W-1:0] any_key();
        return {$urandom, $urandom};
    endfunction

    // Swaps bytes of equal parity; with two hash lanes the bucket is kept.
    function automatic logic [KEY_W-1:0] swap_lanes(logic [KEY_W-1:0] k);
        int         a;
        int         b;
        logic [7:0] t;
        repeat ($urandom_range(1, 3)) begin
            a = $urandom_range(0, 7);
            b = (a + 2 * $urandom_range(1, 3)) % 8;
            t = k[8*a +: 8];
            k[8*a +: 8] = k[8*b +: 8];
            k[8*b +: 8] = t;
        end
        return k;
    endfunction

    task automatic new_base_keys(input int n);
        logic [KEY_W-1:0] k;
        base_keys.delete();
        repeat (n) begin
            k = any_key();
            if ($urandom_range(0, 1) == 0)
                k[8 * $urandom_range(0, 7) +: 8] = 8'h00;
            base_keys.push_back(k);
        end
    endtask

    function automatic logic [KEY_W-1:0] make_key();
        logic [KEY_W-1:0] k;
        k = base_keys[$urandom_range(0, base_keys.size() - 1)];
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5, 6:    k = swap_lanes(k);   // bucket mate, maybe equal past a zero
            7:          k = any_key();
            default:    k[8 * $urandom_range(0, 7) +: 8] = 8'h00;  // short key
        endcase
        return k;
    endfunction

    function automatic logic [1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 46)
            return CMD_INSERT;
        else if (r < 92)
            return CMD_PROBE;
        else if (r < 96)
            return CMD_CLEAR;
        return CMD_NOP;
    endfunction

    // Fills the pool past capacity (every sixteenth key goes to one long chain), probes it, then clears.
    task automatic fill_pool();
        logic [KEY_W-1:0] chain_key;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] built[$];
        send_word(CMD_CLEAR, any_key());
        chain_key = any_key();
        for (int i = 0; i < POOL_DEPTH + 6; i++) begin
            k = (i % 16 == 0) ? swap_lanes(chain_key) : any_key();
            built.push_back(k);
            send_word(CMD_INSERT, k);
        end
        repeat (40) begin
            if ($urandom_range(0, 3) == 0)
                k = any_key();
            else if ($urandom_range(0, 1) == 0)
                k = built[16 * $urandom_range(0, (POOL_DEPTH + 5) / 16)];
            else
                k = built[$urandom_range(0, built.size() - 1)];
            send_word(CMD_PROBE, k);
        end
        send_word(CMD_CLEAR, any_key());
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    initial begin
        t_row       dir_rows[$];
        logic [1:0] cmd;
        int         random_items;
        int         phase;

        empty_table();
        dir_rows = '{
            '{CMD_PROBE,  64'h0,    1'b1, 1'b0, NO_WORD},  // empty table, no word
            '{CMD_PROBE,  KEY_ONES, 1'b1, 1'b0, NO_WORD},
            '{CMD_INSERT, 64'h0,    1'b1, 1'b0, NO_WORD},
            '{CMD_PROBE,  64'h0,    1'b1, 1'b1, t_result'{ST_MATCH, 64'h0}},
            '{CMD_PROBE,  64'h0,    1'b1, 1'b0, NO_WORD},  // already unlinked
            '{CMD_INSERT, KEY_ONES, 1'b1, 1'b0, NO_WORD},
            '{CMD_INSERT, KEY_SEQ,  1'b1, 1'b0, NO_WORD},
            '{CMD_PROBE,  KEY_SEQ,  1'b1, 1'b1, t_result'{ST_MATCH, KEY_SEQ}},
            '{CMD_PROBE,  KEY_ONES, 1'b1, 1'b1, t_result'{ST_MATCH, KEY_ONES}},
            // chain C -> B -> A: unlink middle, head, tail
            '{CMD_INSERT, KEY_A,    1'b0, 1'b0, NO_WORD},
            '{CMD_INSERT, KEY_B,    1'b0, 1'b0, NO_WORD},
            '{CMD_INSERT, KEY_C,    1'b0, 1'b0, NO_WORD},
            '{CMD_PROBE,  KEY_B,    1'b0, 1'b0, NO_WORD},
            '{CMD_PROBE,  KEY_C,    1'b0, 1'b0, NO_WORD},
            '{CMD_PROBE,  KEY_A,    1'b0, 1'b0, NO_WORD},
            '{CMD_PROBE,  KEY_B,    1'b0, 1'b0, NO_WORD},
            '{CMD_INSERT, KEY_T1,   1'b0, 1'b0, NO_WORD},
            '{CMD_PROBE,  KEY_T2,   1'b0, 1'b0, NO_WORD},  // echoes the probe key
            '{CMD_PROBE,  KEY_T1,   1'b0, 1'b0, NO_WORD},
            '{CMD_INSERT, KEY_D,    1'b0, 1'b0, NO_WORD},
            '{CMD_NOP,    KEY_D,    1'b1, 1'b0, NO_WORD},  // ignored, table intact
            '{CMD_PROBE,  KEY_D,    1'b1, 1'b1, t_result'{ST_MATCH, KEY_D}},
            '{CMD_INSERT, KEY_D,    1'b0, 1'b0, NO_WORD},
            '{CMD_CLEAR,  KEY_D,    1'b1, 1'b0, NO_WORD},
            '{CMD_PROBE,  KEY_D,    1'b1, 1'b0, NO_WORD}   // gone after clear
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].pinned,
                      dir_rows[i].hit, dir_rows[i].word);
        drain();

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (phase == 4)
                fill_pool();
            new_base_keys($urandom_range(3, 12));
            repeat ($urandom_range(20, 60)) begin
                cmd = pick_command();
                send_word(cmd, make_key());
                if (cmd != CMD_NOP)
                    random_items++;
            end
            if (phase == 0 || $urandom_range(0, 3) == 0)
                drain();
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
